>>> rtl/percent_decoder_assert.svh
// ----------------------------------------------------------------------------
// percent_decoder_assert.svh
// Assertion macros shared by the percent decoder.
// ----------------------------------------------------------------------------
`ifndef PERCENT_DECODER_ASSERT_SVH
`define PERCENT_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on clk and off during reset.
`define PCTD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("percent decoder assertion failed");

// Next-cycle implication, sampled on clk and off during reset.
`define PCTD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("percent decoder assertion failed");

`endif

>>> rtl/pctd_pkg.sv
// ----------------------------------------------------------------------------
// pctd_pkg
// Types, constants and character helpers for the percent decoder.
// ----------------------------------------------------------------------------
package pctd_pkg;

	localparam logic [7:0] PCT_CHAR = 8'h25;
	localparam int GRP_BYTES = 3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_last;
	} out_word_t;

	typedef struct packed {
		logic [GRP_BYTES-1:0][7:0] bytes;
		logic [1:0]                cnt;
		logic                      last;
	} group_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic is_hex(input logic [7:0] ch);
		return ch inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
	endfunction

	function automatic logic [3:0] hex_value(input logic [7:0] ch);
		logic [7:0] t;
		t = 8'h00;
		if (ch inside {[8'h30:8'h39]}) begin
			t = ch - 8'h30;
		end else if (ch inside {[8'h61:8'h66]}) begin
			t = ch - 8'h57;
		end else if (ch inside {[8'h41:8'h46]}) begin
			t = ch - 8'h37;
		end
		return t[3:0];
	endfunction

endpackage

>>> rtl/percent_decoder.sv
// ----------------------------------------------------------------------------
// percent_decoder: streaming URL percent decoder.
// Path: a pushed byte is registered in the queue, then in the back stage, before it reaches the result ports.
// Throughput: one word per cycle while the queue is not full; a word yielding k bytes is handed out as k result words.
// Reset: arst_n clears escape state, queue and output at once; no sweep.
// ----------------------------------------------------------------------------
`include "percent_decoder_assert.svh"

module percent_decoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  pctd_pkg::in_word_t  item,
	output logic                empty,
	input  logic                pop,
	output pctd_pkg::out_word_t result
);

	pctd_pkg::group_t    grp;
	pctd_pkg::group_t    qdata;
	pctd_pkg::q_status_t q_stat;
	logic                accept;
	logic                qwr;
	logic                qpop;

	assign full   = q_stat.full;
	assign accept = push && !q_stat.full;
	assign qwr    = accept && (grp.cnt != 2'd0);

	pctd_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.grp    (grp)
	);

	pctd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (qwr),
		.wdata  (grp),
		.rd     (qpop),
		.rdata  (qdata),
		.status (q_stat)
	);

	pctd_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qdata  (qdata),
		.qempty (q_stat.empty),
		.qpop   (qpop),
		.pop    (pop),
		.empty  (empty),
		.result (result)
	);

	`PCTD_ASSERT_NOW(a_queue_sane, 1'b1, !(q_stat.full && q_stat.empty))
	`PCTD_ASSERT_NOW(a_last_yields, accept && item.in_last, grp.cnt != 2'd0)
	`PCTD_ASSERT_NEXT(a_word_reaches_out, qwr && q_stat.empty && empty, !q_stat.empty)

endmodule

>>> rtl/pctd_front.sv
// ----------------------------------------------------------------------------
// pctd_front
// Accepts words, tracks the escape state and builds a group of output bytes.
// ----------------------------------------------------------------------------
module pctd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  pctd_pkg::in_word_t item,
	output pctd_pkg::group_t  grp
);

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_PCT  = 2'd1;
	localparam logic [1:0] PH_DIG  = 2'd2;

	logic [1:0] phase_q;
	logic [7:0] digit_q;
	logic [1:0] phase_d;
	logic [7:0] digit_d;

	always_comb begin
		logic [7:0] b;
		logic       consumed;
		logic [1:0] n;
		b        = item.in_byte;
		consumed = 1'b0;
		n        = 2'd0;
		phase_d  = phase_q;
		digit_d  = digit_q;
		grp.bytes = '0;
		case (phase_q)
			PH_PCT: begin
				if (pctd_pkg::is_hex(b)) begin
					phase_d  = PH_DIG;
					digit_d  = b;
					consumed = 1'b1;
				end else begin
					grp.bytes[n] = pctd_pkg::PCT_CHAR;
					n = n + 2'd1;
					phase_d = PH_IDLE;
				end
			end
			PH_DIG: begin
				if (pctd_pkg::is_hex(b)) begin
					grp.bytes[n] = {pctd_pkg::hex_value(digit_q), pctd_pkg::hex_value(b)};
					n = n + 2'd1;
					consumed = 1'b1;
				end else begin
					grp.bytes[n] = pctd_pkg::PCT_CHAR;
					n = n + 2'd1;
					grp.bytes[n] = digit_q;
					n = n + 2'd1;
				end
				phase_d = PH_IDLE;
				digit_d = 8'h00;
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
		if (!consumed) begin
			if (b == pctd_pkg::PCT_CHAR) begin
				phase_d = PH_PCT;
			end else begin
				grp.bytes[n] = b;
				n = n + 2'd1;
			end
		end
		if (item.in_last) begin
			if (phase_d == PH_PCT) begin
				grp.bytes[n] = pctd_pkg::PCT_CHAR;
				n = n + 2'd1;
			end else if (phase_d == PH_DIG) begin
				grp.bytes[n] = pctd_pkg::PCT_CHAR;
				n = n + 2'd1;
				grp.bytes[n] = digit_d;
				n = n + 2'd1;
			end
			phase_d = PH_IDLE;
			digit_d = 8'h00;
		end
		grp.cnt  = n;
		grp.last = item.in_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			digit_q <= 8'h00;
		end else if (accept) begin
			phase_q <= phase_d;
			digit_q <= digit_d;
		end
	end

endmodule

>>> rtl/pctd_fifo.sv
// ----------------------------------------------------------------------------
// pctd_fifo
// Two-entry queue of byte groups between the front and the back.
// ----------------------------------------------------------------------------
module pctd_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr,
	input  pctd_pkg::group_t     wdata,
	input  logic                 rd,
	output pctd_pkg::group_t     rdata,
	output pctd_pkg::q_status_t  status
);

	pctd_pkg::group_t mem [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	assign status.full  = (cnt_q == 2'd2);
	assign status.empty = (cnt_q == 2'd0);
	assign rdata        = mem[rptr_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (wr) begin
				wptr_q <= ~wptr_q;
			end
			if (rd) begin
				rptr_q <= ~rptr_q;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

>>> rtl/pctd_back.sv
// ----------------------------------------------------------------------------
// pctd_back
// Holds the current byte group and hands its bytes out one word at a time.
// ----------------------------------------------------------------------------
module pctd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  pctd_pkg::group_t    qdata,
	input  logic                qempty,
	output logic                qpop,
	input  logic                pop,
	output logic                empty,
	output pctd_pkg::out_word_t result
);

	pctd_pkg::group_t grp_q;
	logic       busy_q;
	logic [1:0] idx_q;
	logic       take;
	logic       at_end;
	logic       done;

	assign take   = busy_q && pop;
	assign at_end = (idx_q == grp_q.cnt - 2'd1);
	assign done   = take && at_end;
	assign qpop   = (!busy_q || done) && !qempty;

	assign empty           = !busy_q;
	assign result.out_byte = grp_q.bytes[idx_q];
	assign result.out_last = grp_q.last && at_end;

	always_ff @(posedge clk) begin
		if (qpop) begin
			grp_q <= qdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (qpop) begin
			busy_q <= 1'b1;
			idx_q  <= 2'd0;
		end else if (done) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (take) begin
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule

>>> tb/percent_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// percent_decoder_tb
// Self-checking bench for the streaming percent decoder. Words go in through
// a queue-style push port with random bursts and gaps. A predictor tracks the
// escape state and queues the decoded bytes each word should produce. Every
// popped word is checked in order against that queue. Directed texts cover
// byte extremes, valid and broken escapes and flushes on the final byte.
// Random texts follow, and the output side is stalled on its own pattern and
// once for a long stretch.
// ----------------------------------------------------------------------------
module percent_decoder_tb;

	typedef enum logic [1:0] {
		ESC_NONE  = 2'd0,
		ESC_PCT   = 2'd1,
		ESC_DIGIT = 2'd2
	} esc_phase_e;

	localparam int STALL_LIMIT = 2000;
	localparam int LONG_HOLD   = 150;

	logic                clk;
	logic                arst_n;
	logic                push;
	logic                full;
	pctd_pkg::in_word_t  item;
	logic                empty;
	logic                pop;
	pctd_pkg::out_word_t result;

	esc_phase_e          phase;
	logic [7:0]          held_digit;
	pctd_pkg::out_word_t decoded_q[$];
	pctd_pkg::out_word_t want;
	int                  err_count;
	int                  burst_left;
	int                  rx_hold;
	logic [7:0]          rx_pattern;
	int                  rx_count;
	int                  idle_cycles;

	percent_decoder uut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic is_hex_digit(input logic [7:0] ch);
		return (ch >= "0" && ch <= "9") || (ch >= "a" && ch <= "f") ||
			(ch >= "A" && ch <= "F");
	endfunction

	function automatic logic [3:0] digit_value(input logic [7:0] ch);
		logic [7:0] v;
		v = 8'h00;
		if (ch >= "0" && ch <= "9") begin
			v = ch - "0";
		end else if (ch >= "a" && ch <= "f") begin
			v = ch - "a" + 8'd10;
		end else if (ch >= "A" && ch <= "F") begin
			v = ch - "A" + 8'd10;
		end
		return v[3:0];
	endfunction

	function automatic logic [7:0] rand_hex_char();
		int r;
		r = $urandom_range(0, 21);
		if (r < 10) begin
			return 8'(r) + "0";
		end else if (r < 16) begin
			return 8'(r - 10) + "a";
		end
		return 8'(r - 16) + "A";
	endfunction

	function automatic logic [7:0] rand_non_hex();
		logic [7:0] b;
		b = 8'($urandom);
		while (is_hex_digit(b)) begin
			b = 8'($urandom);
		end
		return b;
	endfunction

	function automatic logic [7:0] rand_plain();
		logic [7:0] b;
		b = 8'($urandom);
		while (b == pctd_pkg::PCT_CHAR) begin
			b = 8'($urandom);
		end
		return b;
	endfunction

	task automatic emit_byte(input logic [7:0] b);
		pctd_pkg::out_word_t w;
		w.out_byte = b;
		w.out_last = 1'b0;
		decoded_q = {decoded_q, w};
	endtask

	// Advances the escape state by one accepted word and queues its bytes.
	task automatic decode_step(input logic [7:0] b, input logic l);
		logic taken;
		int   start_size;
		taken = 1'b0;
		start_size = decoded_q.size();
		case (phase)
			ESC_PCT: begin
				if (is_hex_digit(b)) begin
					phase = ESC_DIGIT;
					held_digit = b;
					taken = 1'b1;
				end else begin
					emit_byte(pctd_pkg::PCT_CHAR);
					phase = ESC_NONE;
				end
			end
			ESC_DIGIT: begin
				if (is_hex_digit(b)) begin
					emit_byte({digit_value(held_digit), digit_value(b)});
					taken = 1'b1;
				end else begin
					emit_byte(pctd_pkg::PCT_CHAR);
					emit_byte(held_digit);
				end
				phase = ESC_NONE;
				held_digit = 8'h00;
			end
			default: begin
				phase = ESC_NONE;
			end
		endcase
		if (!taken) begin
			if (b == pctd_pkg::PCT_CHAR) begin
				phase = ESC_PCT;
			end else begin
				emit_byte(b);
			end
		end
		if (l) begin
			if (phase == ESC_PCT) begin
				emit_byte(pctd_pkg::PCT_CHAR);
			end else if (phase == ESC_DIGIT) begin
				emit_byte(pctd_pkg::PCT_CHAR);
				emit_byte(held_digit);
			end
			phase = ESC_NONE;
			held_digit = 8'h00;
			if (decoded_q.size() > start_size) begin
				decoded_q[decoded_q.size() - 1].out_last = 1'b1;
			end
		end
	endtask

	task automatic send_word(input logic [7:0] b, input logic l);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				push <= 1'b0;
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		@(negedge clk);
		push <= 1'b1;
		item.in_byte <= b;
		item.in_last <= l;
		do @(posedge clk); while (full);
		decode_step(b, l);
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++) begin
			send_word(s[i], i == s.len() - 1);
		end
	endtask

	task automatic send_random_text(input int min_segments, output int n_sent);
		int         seg;
		int         n_seg;
		int         kind;
		logic [7:0] txt[$];
		txt = {};
		n_seg = $urandom_range(min_segments, 6);
		for (seg = 0; seg < n_seg; seg++) begin
			kind = $urandom_range(0, 9);
			if (kind < 4) begin
				txt = {txt, rand_plain()};
			end else if (kind < 7) begin
				txt = {txt, pctd_pkg::PCT_CHAR};
				txt = {txt, rand_hex_char()};
				txt = {txt, rand_hex_char()};
			end else if (kind == 7) begin
				txt = {txt, pctd_pkg::PCT_CHAR};
				txt = {txt, ($urandom_range(0, 2) == 0) ? pctd_pkg::PCT_CHAR :
					rand_non_hex()};
			end else if (kind == 8) begin
				txt = {txt, pctd_pkg::PCT_CHAR};
				txt = {txt, rand_hex_char()};
				txt = {txt, ($urandom_range(0, 2) == 0) ? pctd_pkg::PCT_CHAR :
					rand_non_hex()};
			end else begin
				txt = {txt, 8'($urandom)};
			end
		end
		// Some texts end in the middle of an escape so the flush path is hit.
		kind = $urandom_range(0, 7);
		if (kind == 0) begin
			txt = {txt, pctd_pkg::PCT_CHAR};
		end else if (kind == 1) begin
			txt = {txt, pctd_pkg::PCT_CHAR};
			txt = {txt, rand_hex_char()};
		end
		for (seg = 0; seg < txt.size(); seg++) begin
			send_word(txt[seg], seg == txt.size() - 1);
		end
		n_sent = txt.size();
	endtask

	task automatic test_plain_bytes();
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b1);
		send_text("A");
	endtask

	task automatic test_valid_escapes();
		send_text("%41");
		send_text("%fF");
		send_text("%A0");
	endtask

	task automatic test_broken_escapes();
		send_text("%g");
		send_text("%4z");
		send_text("%4%");
	endtask

	task automatic test_last_flush();
		send_text("%");
		send_text("%7");
	endtask

	task automatic test_output_backpressure();
		int total;
		int n;
		total = 0;
		@(negedge clk);
		push <= 1'b0;
		rx_hold = LONG_HOLD;
		while (total < 40) begin
			send_random_text(3, n);
			total += n;
		end
	endtask

	task automatic test_drain_pause();
		send_text("a%2Fb%");
		send_text("%3d%4");
		@(negedge clk);
		push <= 1'b0;
		while (decoded_q.size() != 0) begin
			@(posedge clk);
		end
		send_text("x%20");
	endtask

	task automatic test_random_text(input int n_items);
		int total;
		int n;
		total = 0;
		while (total < n_items) begin
			send_random_text(1, n);
			total += n;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (decoded_q.size() == 0) begin
				$error("unexpected word: out_byte %02h out_last %0b",
					result.out_byte, result.out_last);
				err_count++;
			end else begin
				want = decoded_q.pop_front();
				if (result.out_byte !== want.out_byte) begin
					$error("out_byte mismatch: expected %02h, got %02h",
						want.out_byte, result.out_byte);
					err_count++;
				end
				if (result.out_last !== want.out_last) begin
					$error("out_last mismatch: expected %0b, got %0b",
						want.out_last, result.out_last);
					err_count++;
				end
			end
		end
	end

	initial begin
		pop = 1'b0;
		rx_hold = 0;
		rx_pattern = 8'hFF;
		rx_count = 0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				rx_hold--;
				pop <= 1'b0;
			end else begin
				pop <= rx_pattern[0];
				rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
				rx_count++;
				if (rx_count == 48) begin
					rx_count = 0;
					rx_pattern = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
					if (rx_pattern == 8'h00) begin
						rx_pattern = 8'h01;
					end
				end
			end
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (push && !full) || (pop && !empty)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
		end
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		phase = ESC_NONE;
		held_digit = 8'h00;
		err_count = 0;
		burst_left = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_plain_bytes();
		test_valid_escapes();
		test_broken_escapes();
		test_last_flush();
		test_output_backpressure();
		test_drain_pause();
		test_random_text(100);
		@(negedge clk);
		push <= 1'b0;
		while (decoded_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		if (err_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl
rtl/pctd_pkg.sv
rtl/pctd_front.sv
rtl/pctd_fifo.sv
rtl/pctd_back.sv
rtl/percent_decoder.sv
tb/percent_decoder_tb.sv
